[hw/rtl/sacl_pkg.sv]
// Package for the set-associative LRU cache simulator.
// Geometry constants, row and lookup types. No dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int CACHE_KB   = 32;
	localparam int WAYS       = 8;
	localparam int LINE_BYTES = 64;
	localparam int ADDR_BITS  = 48;

	// port widths fixed by the interface
	localparam int ADDR_W   = 48;
	localparam int STAMP_W  = 64;
	localparam int COUNT_W  = 64;
	localparam int WAYOUT_W = 3;

	// geometry is assumed to be powers of two
	localparam int RAW_SETS  = (CACHE_KB * 1024) / (WAYS * LINE_BYTES);
	localparam int SET_COUNT = (RAW_SETS > 0) ? RAW_SETS : 1;
	localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OFF_W     = $clog2(LINE_BYTES);
	localparam int LINE_W    = ADDR_W - OFF_W;
	localparam int PAD       = 1 << WAY_W;

	localparam logic [SET_W-1:0] SET_MASK = SET_W'(SET_COUNT - 1);
	localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	// one set: all its ways side by side
	typedef struct packed {
		logic [WAYS-1:0]              valid;
		logic [WAYS-1:0][LINE_W-1:0]  tag;
		logic [WAYS-1:0][STAMP_W-1:0] stamp;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
	} pick_t;

endpackage

[hw/rtl/sacl_set_store.sv]
// Set storage: one memory row per set plus per-row written bits.
// Forwards a same-cycle row write to a read of that set. Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_set_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sacl_pkg::SET_W-1:0] rd_set,
	input  logic                      wr_en,
	input  logic [sacl_pkg::SET_W-1:0] wr_set,
	input  sacl_pkg::row_t            wr_row,
	output sacl_pkg::row_t            rd_row
);

	sacl_pkg::row_t mem [sacl_pkg::SET_COUNT];
	logic [sacl_pkg::SET_COUNT-1:0] written_q;

	sacl_pkg::row_t rd_data_q;
	sacl_pkg::row_t byp_row_q;
	logic           byp_q;
	logic           rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_set];
			byp_row_q <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			byp_q     <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				byp_q   <= wr_en && (wr_set == rd_set);
				rd_ok_q <= written_q[rd_set];
			end
		end
	end

	// a never-written set reads as all ways empty
	always_comb begin
		if (byp_q) begin
			rd_row = byp_row_q;
		end else if (rd_ok_q) begin
			rd_row = rd_data_q;
		end else begin
			rd_row = '0;
		end
	end

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (rd_set == wr_set) |=> rd_row == $past(wr_row))
		else $error("same-set write not forwarded to read");

endmodule

[hw/rtl/sacl_way_select.sv]
// Tag lookup and LRU victim choice for one set row.
// Builds the updated row. Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_way_select (
	input  sacl_pkg::row_t                  row,
	input  logic [sacl_pkg::LINE_W-1:0]     line,
	input  logic [sacl_pkg::STAMP_W-1:0]    stamp,
	output sacl_pkg::pick_t                 pick,
	output sacl_pkg::row_t                  new_row
);

	logic                        hit;
	logic [sacl_pkg::WAY_W-1:0]  hit_way;
	logic                        empty;
	logic [sacl_pkg::WAY_W-1:0]  empty_way;
	logic [sacl_pkg::WAY_W-1:0]  chosen;

	logic [sacl_pkg::STAMP_W-1:0] node_val [2*sacl_pkg::PAD];
	logic [sacl_pkg::WAY_W-1:0]   node_way [2*sacl_pkg::PAD];

	// lowest matching way and lowest empty way
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		empty     = 1'b0;
		empty_way = '0;
		for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
			if (row.valid[w] && row.tag[w] == line) begin
				hit     = 1'b1;
				hit_way = sacl_pkg::WAY_W'(w);
			end
			if (!row.valid[w]) begin
				empty     = 1'b1;
				empty_way = sacl_pkg::WAY_W'(w);
			end
		end
	end

	// min tree over stamps; left wins ties so the lowest index is kept
	always_comb begin
		node_val[0] = '0;
		node_way[0] = '0;
		for (int i = 0; i < sacl_pkg::PAD; i++) begin
			if (i < sacl_pkg::WAYS) begin
				node_val[sacl_pkg::PAD + i] = row.stamp[i];
			end else begin
				node_val[sacl_pkg::PAD + i] = '1;
			end
			node_way[sacl_pkg::PAD + i] = sacl_pkg::WAY_W'(i);
		end
		for (int n = sacl_pkg::PAD - 1; n >= 1; n--) begin
			if (node_val[2*n+1] < node_val[2*n]) begin
				node_val[n] = node_val[2*n+1];
				node_way[n] = node_way[2*n+1];
			end else begin
				node_val[n] = node_val[2*n];
				node_way[n] = node_way[2*n];
			end
		end
	end

	always_comb begin
		if (hit) begin
			chosen = hit_way;
		end else if (empty) begin
			chosen = empty_way;
		end else begin
			chosen = node_way[1];
		end
		pick.hit = hit;
		pick.way = chosen;

		new_row = row;
		new_row.stamp[chosen] = stamp;
		if (!hit) begin
			new_row.tag[chosen]   = line;
			new_row.valid[chosen] = 1'b1;
		end
	end

endmodule

[hw/rtl/set_assoc_cache_lru_sim_top.sv]
// Top level of the set-associative LRU cache simulator.
// Result strobe (done) follows an accepted start through the vld_s1 and done_q registers.
// Throughput: one address per cycle; busy is always low, no stall.
// The set row is read at accept and written back in the cycle after.
// Reset: all sets empty at once (per-set written bits), clock = 1, counts = 0.
// Depends on sacl_pkg, sacl_set_store, sacl_way_select.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sacl_pkg::ADDR_W-1:0]    address,
	output logic                           done,
	output logic                           hit,
	output logic [sacl_pkg::WAYOUT_W-1:0]  way_used,
	output logic [sacl_pkg::COUNT_W-1:0]   hit_total,
	output logic [sacl_pkg::COUNT_W-1:0]   miss_total
);

	logic                          accept;
	logic [sacl_pkg::ADDR_W-1:0]   addr_m;
	logic [sacl_pkg::LINE_W-1:0]   line_in;
	logic [sacl_pkg::SET_W-1:0]    set_in;

	logic                          vld_s1;
	logic [sacl_pkg::LINE_W-1:0]   line_s1;
	logic [sacl_pkg::SET_W-1:0]    set_s1;
	logic [sacl_pkg::STAMP_W-1:0]  stamp_s1;

	logic [sacl_pkg::STAMP_W-1:0]  clock_q;
	logic [sacl_pkg::COUNT_W-1:0]  hit_cnt_q;
	logic [sacl_pkg::COUNT_W-1:0]  miss_cnt_q;
	logic                          done_q;
	logic                          hit_q;
	logic [sacl_pkg::WAYOUT_W-1:0] way_q;

	sacl_pkg::row_t  row_s1;
	sacl_pkg::row_t  new_row;
	sacl_pkg::pick_t pick;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign addr_m  = address & sacl_pkg::ADDR_MASK;
	assign line_in = addr_m[sacl_pkg::ADDR_W-1:sacl_pkg::OFF_W];
	assign set_in  = line_in[sacl_pkg::SET_W-1:0] & sacl_pkg::SET_MASK;

	sacl_set_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_set (set_in),
		.wr_en  (vld_s1),
		.wr_set (set_s1),
		.wr_row (new_row),
		.rd_row (row_s1)
	);

	sacl_way_select u_select (
		.row     (row_s1),
		.line    (line_s1),
		.stamp   (stamp_s1),
		.pick    (pick),
		.new_row (new_row)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1  <= line_in;
			set_s1   <= set_in;
			stamp_s1 <= clock_q;
		end
		if (vld_s1) begin
			hit_q <= pick.hit;
			way_q <= sacl_pkg::WAYOUT_W'(pick.way);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
			clock_q    <= sacl_pkg::STAMP_W'(1);
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			vld_s1 <= accept;
			done_q <= vld_s1;
			if (accept) begin
				clock_q <= clock_q + sacl_pkg::STAMP_W'(1);
			end
			if (vld_s1) begin
				if (pick.hit) begin
					hit_cnt_q <= hit_cnt_q + sacl_pkg::COUNT_W'(1);
				end else begin
					miss_cnt_q <= miss_cnt_q + sacl_pkg::COUNT_W'(1);
				end
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign way_used   = way_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(vld_s1))
		else $error("result strobe without a word in flight");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q + miss_cnt_q) + 64'd1))
		else $error("counts did not advance by exactly one");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> $stable(hit_cnt_q) && $stable(miss_cnt_q))
		else $error("counts moved without a result");

endmodule

[tb/set_assoc_cache_lru_sim_top_tb.sv]
// Self-checking bench for the set-associative LRU cache simulator top level.
// Drives address words, predicts hit/way/totals in SV, checks every result.
// Depends on sacl_pkg and set_assoc_cache_lru_sim_top.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_top_tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_WORDS   = 1250;
	localparam int HOT_DEPTH      = 24;
	localparam int CONFLICT_TAGS  = 12;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CTAG_W         = sacl_pkg::LINE_W - sacl_pkg::SET_W;

	typedef struct packed {
		logic                          hit;
		logic [sacl_pkg::WAYOUT_W-1:0] way;
		logic [sacl_pkg::COUNT_W-1:0]  hits;
		logic [sacl_pkg::COUNT_W-1:0]  misses;
	} access_outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [sacl_pkg::ADDR_W-1:0]   address = '0;
	logic                          busy;
	logic                          done;
	logic                          hit;
	logic [sacl_pkg::WAYOUT_W-1:0] way_used;
	logic [sacl_pkg::COUNT_W-1:0]  hit_total;
	logic [sacl_pkg::COUNT_W-1:0]  miss_total;

	logic [sacl_pkg::ADDR_W-1:0]   pending_q [$];
	access_outcome_t               outcome_q [$];
	int                            err_count = 0;
	int                            idle_cycles = 0;
	int                            burst_left = 0;
	int                            gap_left = 0;

	// shadow cache
	logic [sacl_pkg::LINE_W-1:0]  shadow_tag   [sacl_pkg::SET_COUNT][sacl_pkg::WAYS];
	logic                         shadow_valid [sacl_pkg::SET_COUNT][sacl_pkg::WAYS];
	logic [sacl_pkg::STAMP_W-1:0] shadow_stamp [sacl_pkg::SET_COUNT][sacl_pkg::WAYS];
	logic [sacl_pkg::STAMP_W-1:0] access_clock;
	logic [sacl_pkg::COUNT_W-1:0] hit_count;
	logic [sacl_pkg::COUNT_W-1:0] miss_count;

	set_assoc_cache_lru_sim_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.address    (address),
		.done       (done),
		.hit        (hit),
		.way_used   (way_used),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

	always #5 clk = ~clk;

	function automatic access_outcome_t cache_access(
		input logic [sacl_pkg::ADDR_W-1:0] addr_in);
		logic [sacl_pkg::LINE_W-1:0]  line_addr;
		logic [sacl_pkg::STAMP_W-1:0] stamp_now;
		logic [sacl_pkg::STAMP_W-1:0] oldest;
		logic                         found;
		int                           set_idx;
		int                           pick;
		access_outcome_t              res;
		line_addr = sacl_pkg::LINE_W'((addr_in & sacl_pkg::ADDR_MASK) >> sacl_pkg::OFF_W);
		set_idx = int'(line_addr % sacl_pkg::SET_COUNT);
		stamp_now = access_clock;
		access_clock = access_clock + sacl_pkg::STAMP_W'(1);
		found = 1'b0;
		pick = 0;
		for (int w = 0; w < sacl_pkg::WAYS; w++)
			if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == line_addr) begin
				found = 1'b1;
				pick = w;
			end
		res.hit = found;
		if (found) begin
			hit_count = hit_count + sacl_pkg::COUNT_W'(1);
		end else begin
			// empty ways fill lowest first; otherwise evict the oldest stamp, low index on tie
			for (int w = sacl_pkg::WAYS - 1; w >= 0; w--)
				if (!shadow_valid[set_idx][w]) begin
					found = 1'b1;
					pick = w;
				end
			if (!found) begin
				oldest = shadow_stamp[set_idx][0];
				for (int w = 1; w < sacl_pkg::WAYS; w++)
					if (shadow_stamp[set_idx][w] < oldest) begin
						oldest = shadow_stamp[set_idx][w];
						pick = w;
					end
			end
			shadow_tag[set_idx][pick] = line_addr;
			shadow_valid[set_idx][pick] = 1'b1;
			miss_count = miss_count + sacl_pkg::COUNT_W'(1);
		end
		shadow_stamp[set_idx][pick] = stamp_now;
		res.way = sacl_pkg::WAYOUT_W'(pick);
		res.hits = hit_count;
		res.misses = miss_count;
		return res;
	endfunction

	// driver: bursts of words with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				outcome_q.push_back(cache_access(address));
			if (!(start && busy)) begin
				if (gap_left > 0 || pending_q.size() == 0) begin
					start <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					start <= 1'b1;
					address <= pending_q.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// monitor: result words can't be held off
	always @(posedge clk) begin : monitor
		access_outcome_t want;
		if (arst_n && done !== 1'b0) begin
			if (outcome_q.size() == 0) begin
				$error("unexpected result word: hit=%0b way_used=%0d", hit, way_used);
				err_count++;
			end else begin
				want = outcome_q.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, hit);
					err_count++;
				end
				if (way_used !== want.way) begin
					$error("way_used: expected %0d, got %0d", want.way, way_used);
					err_count++;
				end
				if (hit_total !== want.hits) begin
					$error("hit_total: expected %0d, got %0d", want.hits, hit_total);
					err_count++;
				end
				if (miss_total !== want.misses) begin
					$error("miss_total: expected %0d, got %0d", want.misses, miss_total);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [sacl_pkg::ADDR_W-1:0] hot_q [$];
		logic [CTAG_W-1:0]           conflict_tag [CONFLICT_TAGS];
		logic [sacl_pkg::ADDR_W-1:0] a;
		logic [sacl_pkg::SET_W-1:0]  set_sel;
		int                          pick;

		for (int s = 0; s < sacl_pkg::SET_COUNT; s++)
			for (int w = 0; w < sacl_pkg::WAYS; w++) begin
				shadow_tag[s][w] = '0;
				shadow_valid[s][w] = 1'b0;
				shadow_stamp[s][w] = '0;
			end
		access_clock = sacl_pkg::STAMP_W'(1);
		hit_count = '0;
		miss_count = '0;

		// line zero must miss into an empty set, then hit
		pending_q.push_back(48'h0);
		pending_q.push_back(48'h3F);
		pending_q.push_back(48'hFFFF_FFFF_FFFF);
		pending_q.push_back(48'hFFFF_FFFF_FFC0);
		// fill set 0, touch way 0, then force LRU evictions
		for (int k = 1; k < sacl_pkg::WAYS; k++)
			pending_q.push_back(sacl_pkg::ADDR_W'(k) << 12);
		pending_q.push_back(48'h0);
		pending_q.push_back(sacl_pkg::ADDR_W'(sacl_pkg::WAYS) << 12);
		pending_q.push_back(48'h1000);
		pending_q.push_back(48'h8000_0000_0000);
		pending_q.push_back(48'hAAAA_AAAA_AAAA);
		pending_q.push_back(48'h5555_5555_5555);

		for (int t = 0; t < CONFLICT_TAGS; t++)
			conflict_tag[t] = CTAG_W'({$urandom, $urandom});

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 && hot_q.size() != 0) begin
				a = hot_q[$urandom_range(0, hot_q.size() - 1)];
				a[sacl_pkg::OFF_W-1:0] = sacl_pkg::OFF_W'($urandom);
			end else if (pick < 85) begin
				// more tags than ways on a few sets: steady eviction traffic
				set_sel = sacl_pkg::SET_W'($urandom_range(0, 3));
				a = {conflict_tag[$urandom_range(0, CONFLICT_TAGS - 1)], set_sel,
					sacl_pkg::OFF_W'($urandom)};
			end else begin
				a = sacl_pkg::ADDR_W'({$urandom, $urandom});
			end
			pending_q.push_back(a);
			hot_q.push_back(a);
			if (hot_q.size() > HOT_DEPTH)
				void'(hot_q.pop_front());
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_set_store.sv
hw/rtl/sacl_way_select.sv
hw/rtl/set_assoc_cache_lru_sim_top.sv
tb/set_assoc_cache_lru_sim_top_tb.sv
